// ===== rtl/size_class_block_allocator_core_assert.svh =====
// Assertion macros used by the allocator top level.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scba_pkg.sv =====
package scba_pkg;

    // Fixed field widths.
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned SIZE_W    = 16;
    localparam int unsigned OFF_W     = 16;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned STAT_W    = 3;
    localparam int unsigned MAXREQ_W  = 10;
    localparam int unsigned SLOT_CAP  = 64;

    // Pool layout.
    localparam int unsigned HDR_BYTES     = 4;
    localparam int unsigned LARGEST_BLOCK = 512;
    localparam int unsigned STRIDE_32     = 32 + HDR_BYTES;
    localparam int unsigned STRIDE_128    = 128 + HDR_BYTES;
    localparam int unsigned STRIDE_256    = 256 + HDR_BYTES;
    localparam int unsigned STRIDE_512    = 512 + HDR_BYTES;

    // Default class populations.
    localparam int unsigned DEF_COUNT_32  = 16;
    localparam int unsigned DEF_COUNT_128 = 12;
    localparam int unsigned DEF_COUNT_256 = 8;
    localparam int unsigned DEF_COUNT_512 = 4;

    localparam logic [MAXREQ_W-1:0] MAX_REQUEST_RESET = MAXREQ_W'(512);

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SLOT      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_REJECT,
        OP_RELEASE,
        OP_CLAIM,
        OP_EXHAUST,
        OP_ADVANCE
    } op_t;

    // Controller to datapath.
    typedef struct packed {
        op_t op;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_free;
        logic reject;
        logic bit_used;
        logic at_last;
    } dp_sts_t;

    // First slot of the smallest class that holds the given size.
    function automatic logic [IDX_W-1:0] class_start(
        input logic [SIZE_W-1:0] size,
        input int unsigned       c32,
        input int unsigned       c128,
        input int unsigned       c256
    );
        logic [IDX_W-1:0] start;
        if (size <= SIZE_W'(32)) begin
            start = '0;
        end else if (size <= SIZE_W'(128)) begin
            start = IDX_W'(c32);
        end else if (size <= SIZE_W'(256)) begin
            start = IDX_W'(c32 + c128);
        end else begin
            start = IDX_W'(c32 + c128 + c256);
        end
        return start;
    endfunction

    // Data offset of a slot: class by class, count slots times block stride.
    function automatic logic [OFF_W-1:0] slot_offset(
        input logic [IDX_W-1:0] idx,
        input int unsigned      c32,
        input int unsigned      c128,
        input int unsigned      c256
    );
        logic [IDX_W:0] rem;
        logic [IDX_W:0] n;
        logic [OFF_W-1:0] off;
        off = OFF_W'(HDR_BYTES);
        rem = {1'b0, idx};
        n   = (rem < (IDX_W+1)'(c32)) ? rem : (IDX_W+1)'(c32);
        off = off + OFF_W'(OFF_W'(n) * OFF_W'(STRIDE_32));
        rem = rem - n;
        n   = (rem < (IDX_W+1)'(c128)) ? rem : (IDX_W+1)'(c128);
        off = off + OFF_W'(OFF_W'(n) * OFF_W'(STRIDE_128));
        rem = rem - n;
        n   = (rem < (IDX_W+1)'(c256)) ? rem : (IDX_W+1)'(c256);
        off = off + OFF_W'(OFF_W'(n) * OFF_W'(STRIDE_256));
        rem = rem - n;
        off = off + OFF_W'(OFF_W'(rem) * OFF_W'(STRIDE_512));
        return off;
    endfunction

endpackage

// ===== rtl/scba_ctrl.sv =====
module scba_ctrl
    import scba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: one scan step per cycle until the request resolves.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (sts.reject || sts.is_free || !sts.bit_used || sts.at_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: datapath command and handshake flags.
    always_comb
    begin
        cmd.op = OP_NONE;
        busy   = 1'b1;
        done   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_WORK:
            begin
                if (sts.reject)
                begin
                    cmd.op = OP_REJECT;
                end
                else if (sts.is_free)
                begin
                    cmd.op = OP_RELEASE;
                end
                else if (!sts.bit_used)
                begin
                    cmd.op = OP_CLAIM;
                end
                else if (sts.at_last)
                begin
                    cmd.op = OP_EXHAUST;
                end
                else
                begin
                    cmd.op = OP_ADVANCE;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/scba_datapath.sv =====
module scba_datapath
    import scba_pkg::*;
#(
    parameter int unsigned COUNT_32  = DEF_COUNT_32,
    parameter int unsigned COUNT_128 = DEF_COUNT_128,
    parameter int unsigned COUNT_256 = DEF_COUNT_256,
    parameter int unsigned COUNT_512 = DEF_COUNT_512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_sts_t             sts,
    input  logic                cfg_we,
    input  logic [MAXREQ_W-1:0] cfg_data,
    input  logic                req_type,
    input  logic [SIZE_W-1:0]   req_size,
    input  logic [IDX_W-1:0]    free_slot,
    output logic [STAT_W-1:0]   status,
    output logic [IDX_W-1:0]    slot_index,
    output logic [OFF_W-1:0]    byte_offset,
    output logic [CNT_W-1:0]    free_count
);

    localparam int unsigned Total = COUNT_32 + COUNT_128 + COUNT_256 + COUNT_512;

    logic [SLOT_CAP-1:0] used_reg;
    logic [SLOT_CAP-1:0] used_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [MAXREQ_W-1:0] max_req_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    ptr_next;
    logic                is_free_reg;
    logic                is_free_next;
    logic                reject_reg;
    logic                reject_next;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_next;
    logic [OFF_W-1:0]    offset_reg;
    logic [OFF_W-1:0]    offset_next;
    logic [OFF_W-1:0]    ptr_offset;
    logic                too_large;
    logic                bad_index;

    // Request checks at acceptance.
    assign too_large = (req_size > SIZE_W'(max_req_reg)) ||
                       (req_size > SIZE_W'(LARGEST_BLOCK));
    assign bad_index = ({1'b0, free_slot} >= (IDX_W+1)'(Total));
    assign ptr_offset = slot_offset(ptr_reg, COUNT_32, COUNT_128, COUNT_256);

    // Status back to the controller.
    assign sts.is_free  = is_free_reg;
    assign sts.reject   = reject_reg;
    assign sts.bit_used = used_reg[ptr_reg];
    assign sts.at_last  = (ptr_reg == IDX_W'(Total - 1));

    // Command decode.
    always_comb
    begin
        used_next    = used_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        is_free_next = is_free_reg;
        reject_next  = reject_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        offset_next  = offset_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
                ptr_next = ptr_reg;
            end
            OP_LOAD:
            begin
                is_free_next = req_type;
                if (req_type)
                begin
                    ptr_next    = free_slot;
                    reject_next = bad_index;
                end
                else
                begin
                    ptr_next    = class_start(req_size, COUNT_32, COUNT_128, COUNT_256);
                    reject_next = too_large;
                end
            end
            OP_REJECT:
            begin
                status_next = is_free_reg ? STAT_BAD_INDEX : STAT_TOO_LARGE;
                slot_next   = is_free_reg ? ptr_reg : '0;
                offset_next = '0;
            end
            OP_RELEASE:
            begin
                slot_next   = ptr_reg;
                offset_next = ptr_offset;
                if (used_reg[ptr_reg])
                begin
                    used_next[ptr_reg] = 1'b0;
                    status_next        = STAT_OK;
                    if (count_reg < CNT_W'(Total))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    status_next = STAT_ALREADY_FREE;
                end
            end
            OP_CLAIM:
            begin
                used_next[ptr_reg] = 1'b1;
                status_next        = STAT_OK;
                slot_next          = ptr_reg;
                offset_next        = ptr_offset;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            OP_EXHAUST:
            begin
                status_next = STAT_NO_SLOT;
                slot_next   = '0;
                offset_next = '0;
            end
            OP_ADVANCE:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // Slot map, free count and limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            count_reg   <= CNT_W'(Total);
            max_req_reg <= MAX_REQUEST_RESET;
        end
        else
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                max_req_reg <= cfg_data;
            end
        end
    end

    // Request and result words.
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        is_free_reg <= is_free_next;
        reject_reg  <= reject_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        offset_reg  <= offset_next;
    end

    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign byte_offset = offset_reg;
    assign free_count  = count_reg;

endmodule

// ===== rtl/size_class_block_allocator_core.sv =====
// Channel   | Handshake                  | Word
// ----------+----------------------------+-------------------------------------------
// request   | start, busy (taken: !busy) | req_type, req_size, free_slot
// result    | done (one-cycle strobe)    | status, slot_index, byte_offset, free_count
// config    | cfg_valid, cfg_ready       | cfg_data (max_request)
//
// A free request or a rejected request is resolved in S_WORK without scanning the slot map.
// An allocation scans from the class start past each used slot until it claims a free one
// or reaches the last slot; the slot map is probed one slot per cycle.
// Reset frees every slot, sets the free count to the pool size and the limit to 512.
// The receiver cannot stall: a result is marked valid only while done is high.
module size_class_block_allocator_core
    import scba_pkg::*;
#(
    parameter int unsigned COUNT_32  = DEF_COUNT_32,
    parameter int unsigned COUNT_128 = DEF_COUNT_128,
    parameter int unsigned COUNT_256 = DEF_COUNT_256,
    parameter int unsigned COUNT_512 = DEF_COUNT_512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [SIZE_W-1:0]   req_size,
    input  logic [IDX_W-1:0]    free_slot,
    output logic                done,
    output logic [STAT_W-1:0]   status,
    output logic [IDX_W-1:0]    slot_index,
    output logic [OFF_W-1:0]    byte_offset,
    output logic [CNT_W-1:0]    free_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MAXREQ_W-1:0] cfg_data
);

`include "size_class_block_allocator_core_assert.svh"

    localparam int unsigned Total = COUNT_32 + COUNT_128 + COUNT_256 + COUNT_512;

    ctl_cmd_t cmd;
    dp_sts_t  sts;
    logic     ctl_busy;

    // The limit register takes a write in any cycle.
    assign cfg_ready = 1'b1;
    assign busy      = ctl_busy;

    scba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (ctl_busy),
        .done  (done)
    );

    scba_datapath #(
        .COUNT_32  (COUNT_32),
        .COUNT_128 (COUNT_128),
        .COUNT_256 (COUNT_256),
        .COUNT_512 (COUNT_512)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .req_size    (req_size),
        .free_slot   (free_slot),
        .status      (status),
        .slot_index  (slot_index),
        .byte_offset (byte_offset),
        .free_count  (free_count)
    );

    // Free count never exceeds the pool size.
    `SCBA_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, free_count <= CNT_W'(Total), "free count above pool size")
    // An accepted request keeps the block busy in the next cycle.
    `SCBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request accepted but block idle")
    // A result strobe is never held and is followed by an idle block.
    `SCBA_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy, "result strobe longer than one cycle")
    // A granted slot always lies inside the pool.
    `SCBA_ASSERT_NOW(a_slot_range, clk, rst_n, done && status == STAT_OK, {1'b0, slot_index} < (IDX_W+1)'(Total), "granted slot outside the pool")

endmodule

// ===== verif/tb_top.sv =====
module tb_top
    import scba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds carried on req_type.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int unsigned POOL_SLOTS =
        DEF_COUNT_32 + DEF_COUNT_128 + DEF_COUNT_256 + DEF_COUNT_512;
    localparam int unsigned DRAIN_CYCLES = 60;

    typedef struct {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  slot;
    } request_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                req_type = REQ_ALLOC;
    logic [SIZE_W-1:0]   req_size = '0;
    logic [IDX_W-1:0]    free_slot = '0;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [IDX_W-1:0]    slot_index;
    logic [OFF_W-1:0]    byte_offset;
    logic [CNT_W-1:0]    free_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MAXREQ_W-1:0] cfg_data = '0;

    // Predicted allocator state.
    bit                  slot_busy [POOL_SLOTS];
    int unsigned         pool_free;
    logic [MAXREQ_W-1:0] size_limit;

    request_t    pending_requests[$];
    grant_t      expected_grants[$];
    request_t    cur;
    bit          holding = 1'b0;
    bit          word_taken = 1'b0;
    bit          steady = 1'b0;
    int unsigned gap_left = 0;
    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned limits_written = 0;
    int unsigned status_seen [8];

    size_class_block_allocator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .req_size    (req_size),
        .free_slot   (free_slot),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index),
        .byte_offset (byte_offset),
        .free_count  (free_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Block stride of the class that a slot belongs to.
    function automatic int unsigned stride_of(input int unsigned idx);
        if (idx < DEF_COUNT_32)
        begin
            return STRIDE_32;
        end
        if (idx < DEF_COUNT_32 + DEF_COUNT_128)
        begin
            return STRIDE_128;
        end
        if (idx < DEF_COUNT_32 + DEF_COUNT_128 + DEF_COUNT_256)
        begin
            return STRIDE_256;
        end
        return STRIDE_512;
    endfunction

    // Data offset: walk the pool from slot 0, skipping each block and its header.
    function automatic logic [OFF_W-1:0] data_offset(input int unsigned idx);
        int unsigned off;
        off = HDR_BYTES;
        for (int unsigned j = 0; j < idx; j++)
        begin
            off += stride_of(j);
        end
        return OFF_W'(off);
    endfunction

    // First slot of the smallest class that can hold the size.
    function automatic int unsigned first_fit_slot(input logic [SIZE_W-1:0] size);
        if (size <= 32)
        begin
            return 0;
        end
        if (size <= 128)
        begin
            return DEF_COUNT_32;
        end
        if (size <= 256)
        begin
            return DEF_COUNT_32 + DEF_COUNT_128;
        end
        return DEF_COUNT_32 + DEF_COUNT_128 + DEF_COUNT_256;
    endfunction

    // Work out the grant for one request and update the predicted pool.
    function automatic grant_t serve_request(input request_t r);
        grant_t g;
        g.status = STAT_OK;
        g.slot   = '0;
        g.offset = '0;
        if (r.op == REQ_ALLOC)
        begin
            if (r.size > size_limit || r.size > LARGEST_BLOCK)
            begin
                g.status = STAT_TOO_LARGE;
            end
            else
            begin
                g.status = STAT_NO_SLOT;
                for (int unsigned i = first_fit_slot(r.size); i < POOL_SLOTS; i++)
                begin
                    if (!slot_busy[i])
                    begin
                        slot_busy[i] = 1'b1;
                        pool_free--;
                        g.status = STAT_OK;
                        g.slot   = IDX_W'(i);
                        g.offset = data_offset(i);
                        break;
                    end
                end
            end
        end
        else
        begin
            g.slot = r.slot;
            if (r.slot >= POOL_SLOTS)
            begin
                g.status = STAT_BAD_INDEX;
            end
            else
            begin
                g.offset = data_offset(r.slot);
                if (!slot_busy[r.slot])
                begin
                    g.status = STAT_ALREADY_FREE;
                end
                else
                begin
                    slot_busy[r.slot] = 1'b0;
                    pool_free++;
                end
            end
        end
        g.count = CNT_W'(pool_free);
        return g;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Monitor: check each result word, then predict any request word taken at this edge.
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d slot %0d offset %0d count %0d",
                             $time, status, slot_index, byte_offset, free_count);
                    errors++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    report_field("status", want.status, status);
                    report_field("slot_index", want.slot, slot_index);
                    report_field("byte_offset", want.offset, byte_offset);
                    report_field("free_count", want.count, free_count);
                    status_seen[status]++;
                end
            end
            if (start && !busy)
            begin
                expected_grants.push_back(serve_request(cur));
                words_sent++;
                word_taken = 1'b1;
            end
        end
    end

    // Driver: present queued request words, with a random gap after each one taken unless steady is set.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_taken)
            begin
                word_taken = 1'b0;
                holding    = 1'b0;
                gap_left   = steady ? 0 : $urandom_range(0, 9);
            end
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_requests.size() > 0)
                begin
                    cur     = pending_requests.pop_front();
                    holding = 1'b1;
                end
            end
            start     <= holding;
            req_type  <= cur.op;
            req_size  <= cur.size;
            free_slot <= cur.slot;
        end
    end

    task automatic push_alloc(input int unsigned size);
        request_t r;
        r.op   = REQ_ALLOC;
        r.size = SIZE_W'(size);
        r.slot = IDX_W'($urandom);
        pending_requests.push_back(r);
    endtask

    task automatic push_free(input int unsigned slot);
        request_t r;
        r.op   = REQ_FREE;
        r.size = SIZE_W'($urandom);
        r.slot = IDX_W'(slot);
        pending_requests.push_back(r);
    endtask

    task automatic write_limit(input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= MAXREQ_W'(value);
        do @(posedge clk); while (!cfg_ready);
        size_limit = MAXREQ_W'(value);
        limits_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Idle means nothing queued, nothing presented and no result outstanding.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || holding || expected_grants.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sizes spread over every class, with some at the class boundaries and some far out of range.
    function automatic int unsigned pick_size();
        int unsigned edges [9] = '{0, 32, 33, 128, 129, 256, 257, 512, 513};
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 32);
            1: return $urandom_range(33, 128);
            2: return $urandom_range(129, 256);
            3: return $urandom_range(257, 512);
            4: return edges[$urandom_range(0, 8)];
            5: return $urandom_range(513, 65535);
            6: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 600);
        endcase
    endfunction

    task automatic queue_random(input int unsigned count, input int unsigned alloc_pct);
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(1, 100) <= alloc_pct)
            begin
                push_alloc(pick_size());
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                push_free($urandom_range(POOL_SLOTS, 63));
            end
            else
            begin
                push_free($urandom_range(0, POOL_SLOTS - 1));
            end
        end
    endtask

    initial
    begin
        int unsigned pct [6] = '{60, 85, 30, 55, 75, 40};
        for (int unsigned i = 0; i < POOL_SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
        end
        pool_free  = POOL_SLOTS;
        size_limit = MAX_REQUEST_RESET;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Class boundaries, oversize, bad index, double free, then one class run dry.
        push_alloc(0);
        push_alloc(32);
        push_alloc(33);
        push_alloc(128);
        push_alloc(129);
        push_alloc(256);
        push_alloc(257);
        push_alloc(512);
        push_alloc(513);
        push_alloc(65535);
        push_free(63);
        push_free(POOL_SLOTS);
        push_free(POOL_SLOTS - 1);
        push_free(0);
        push_free(0);
        push_free(37);
        push_alloc(512);
        push_alloc(512);
        push_alloc(512);
        push_alloc(400);
        wait_idle();

        // Smallest limit: only a zero-size request gets through.
        write_limit(0);
        push_alloc(0);
        push_alloc(1);
        push_alloc(512);
        wait_idle();

        // Random phases, each under a newly written limit and its own alloc/free mix.
        for (int unsigned p = 0; p < 6; p++)
        begin
            case (p)
                0: write_limit(512);
                1: write_limit($urandom_range(1, 511));
                2: write_limit(0);
                3: write_limit(33);
                4: write_limit($urandom_range(0, 512));
                default: write_limit(512);
            endcase
            steady = (p % 3 == 2);
            queue_random(150, pct[p]);
            wait_idle();
        end

        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d requests under %0d limit settings.", words_sent, limits_written);
        $display("Results: ok %0d, too large %0d, no slot %0d, bad index %0d, already free %0d.",
                 status_seen[STAT_OK], status_seen[STAT_TOO_LARGE], status_seen[STAT_NO_SLOT],
                 status_seen[STAT_BAD_INDEX], status_seen[STAT_ALREADY_FREE]);
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", expected_grants.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ctrl.sv
rtl/scba_datapath.sv
rtl/size_class_block_allocator_core.sv
verif/tb_top.sv
